### rtl/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wavhp_pkg
// types and constants shared by the wav header parser modules
// ----------------------------------------------------------------------------
`default_nettype none

package wavhp_pkg;

  localparam logic [31:0] TAG_WAVE      = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT       = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA      = 32'h6174_6164;
  localparam logic [31:0] FMT_BASE_SIZE = 32'd16;
  localparam int unsigned DEPTH_ALIGN_BITS = 3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_WAVE  = 3'd1,
    ST_BAD_DEPTH = 3'd2,
    ST_NO_FMT    = 3'd3,
    ST_NO_DATA   = 3'd4
  } status_e;

  typedef enum logic [13:0] {
    PH_IDLE    = 14'b00000000000001,
    PH_HEADER  = 14'b00000000000010,
    PH_WAVE    = 14'b00000000000100,
    PH_ID1     = 14'b00000000001000,
    PH_SIZE1   = 14'b00000000010000,
    PH_SKIP1   = 14'b00000000100000,
    PH_FMTSIZE = 14'b00000001000000,
    PH_FMTBODY = 14'b00000010000000,
    PH_EXT     = 14'b00000100000000,
    PH_ID2     = 14'b00001000000000,
    PH_SIZE2   = 14'b00010000000000,
    PH_SKIP2   = 14'b00100000000000,
    PH_DLEN    = 14'b01000000000000,
    PH_DONE    = 14'b10000000000000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } wavhp_in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] data_length;
    logic [31:0] data_offset;
  } wavhp_out_t;

  typedef struct packed {
    logic       valid;
    wavhp_out_t data;
  } wavhp_res_t;

endpackage

`default_nettype wire

### rtl/wavhp_stream_if.sv
// ----------------------------------------------------------------------------
// wavhp_stream_if
// valid/ready stream carrying one payload per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface wavhp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/wavhp_parser.sv
// ----------------------------------------------------------------------------
// wavhp_parser
// parse state and per-byte next-state logic; flags a result on the beat
// that completes or aborts the parse
// ----------------------------------------------------------------------------
`default_nettype none

module wavhp_parser
  import wavhp_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        fire_i,
  input  wire wavhp_in_t beat_i,
  output wavhp_res_t res_o
);

  phase_e      phase_q, phase_d, phase_c;
  logic [1:0]  idx_q, idx_d, idx_c;
  logic [31:0] asm_q, asm_d, asm_c, asm_tk;
  logic [31:0] skip_q, skip_d, skip_c;
  logic [31:0] pos_q, pos_d, pos_c, off_c;
  logic [31:0] fsz_q, fsz_d, fsz_c;
  logic [15:0] ch_q, ch_d, ch_c;
  logic [31:0] rate_q, rate_d, rate_c;
  logic [15:0] dep_q, dep_d, dep_c;
  logic        active, tk_done, emit;
  logic [3:0]  ofs;
  logic [7:0]  b;
  status_e     err_st;

  always_comb begin
    b = beat_i.data_byte;
    if (beat_i.first_byte) begin
      phase_c = PH_HEADER;
      idx_c   = '0;
      asm_c   = '0;
      skip_c  = '0;
      pos_c   = '0;
      off_c   = 32'd1;
      fsz_c   = '0;
      ch_c    = '0;
      rate_c  = '0;
      dep_c   = '0;
    end else begin
      phase_c = phase_q;
      idx_c   = idx_q;
      asm_c   = asm_q;
      skip_c  = skip_q;
      pos_c   = pos_q + 32'd1;
      off_c   = pos_q + 32'd2;
      fsz_c   = fsz_q;
      ch_c    = ch_q;
      rate_c  = rate_q;
      dep_c   = dep_q;
    end
    active  = beat_i.first_byte || !(phase_q == PH_IDLE || phase_q == PH_DONE);
    asm_tk  = {b, asm_c[31:8]};
    tk_done = (idx_c == 2'd3);
    ofs     = skip_c[3:0];

    phase_d = phase_q;
    idx_d   = idx_q;
    asm_d   = asm_q;
    skip_d  = skip_q;
    pos_d   = pos_q;
    fsz_d   = fsz_q;
    ch_d    = ch_q;
    rate_d  = rate_q;
    dep_d   = dep_q;
    emit    = 1'b0;
    res_o   = '0;
    err_st  = ST_NO_DATA;

    if (fire_i && active) begin
      phase_d = phase_c;
      idx_d   = idx_c;
      asm_d   = asm_c;
      skip_d  = skip_c;
      pos_d   = pos_c;
      fsz_d   = fsz_c;
      ch_d    = ch_c;
      rate_d  = rate_c;
      dep_d   = dep_c;

      unique case (phase_c) inside
        PH_HEADER: begin
          if (pos_c == 32'd7) phase_d = PH_WAVE;
        end
        PH_WAVE: begin
          asm_d = asm_tk;
          idx_d = idx_c + 2'd1;
          if (tk_done) begin
            if (asm_tk != TAG_WAVE) begin
              emit              = 1'b1;
              res_o.data.status = ST_NOT_WAVE;
              phase_d           = PH_DONE;
            end else begin
              phase_d = PH_ID1;
            end
          end
        end
        PH_ID1, PH_ID2: begin
          asm_d = asm_tk;
          idx_d = idx_c + 2'd1;
          if (tk_done) begin
            if (phase_c == PH_ID1) phase_d = (asm_tk == TAG_FMT) ? PH_FMTSIZE : PH_SIZE1;
            else phase_d = (asm_tk == TAG_DATA) ? PH_DLEN : PH_SIZE2;
          end
        end
        PH_SIZE1, PH_SIZE2: begin
          asm_d = asm_tk;
          idx_d = idx_c + 2'd1;
          if (tk_done) begin
            skip_d = asm_tk;
            if (asm_tk != '0) phase_d = (phase_c == PH_SIZE1) ? PH_SKIP1 : PH_SKIP2;
            else phase_d = (phase_c == PH_SIZE1) ? PH_ID1 : PH_ID2;
          end
        end
        PH_SKIP1, PH_SKIP2, PH_EXT: begin
          skip_d = skip_c - 32'd1;
          if (skip_d == '0) phase_d = (phase_c == PH_SKIP1) ? PH_ID1 : PH_ID2;
        end
        PH_FMTSIZE: begin
          asm_d = asm_tk;
          idx_d = idx_c + 2'd1;
          if (tk_done) begin
            fsz_d   = asm_tk;
            skip_d  = '0;
            phase_d = PH_FMTBODY;
          end
        end
        PH_FMTBODY: begin
          case (ofs)
            4'd2:    ch_d = {8'h00, b};
            4'd3:    ch_d[15:8] = b;
            4'd4:    rate_d[7:0] = b;
            4'd5:    rate_d[15:8] = b;
            4'd6:    rate_d[23:16] = b;
            4'd7:    rate_d[31:24] = b;
            4'd14:   dep_d = {8'h00, b};
            4'd15:   dep_d[15:8] = b;
            default: ;
          endcase
          skip_d = {28'h0, ofs} + 32'd1;
          if (ofs == 4'd15) begin
            if (dep_c[DEPTH_ALIGN_BITS-1:0] != '0) begin
              emit              = 1'b1;
              res_o.data.status = ST_BAD_DEPTH;
              phase_d           = PH_DONE;
            end else if (fsz_c > FMT_BASE_SIZE) begin
              skip_d  = fsz_c - FMT_BASE_SIZE;
              phase_d = PH_EXT;
            end else begin
              skip_d  = '0;
              phase_d = PH_ID2;
            end
          end
        end
        PH_DLEN: begin
          asm_d = asm_tk;
          idx_d = idx_c + 2'd1;
          if (tk_done) begin
            emit                       = 1'b1;
            res_o.data.status          = ST_OK;
            res_o.data.channels        = ch_c;
            res_o.data.sample_rate     = rate_c;
            res_o.data.bits_per_sample = dep_c;
            res_o.data.data_length     = asm_tk;
            res_o.data.data_offset     = off_c;
            phase_d                    = PH_DONE;
          end
        end
        default: ;
      endcase

      // end of file with the parse still open
      if (!emit && beat_i.last_byte && phase_d != PH_DONE) begin
        case (phase_d) inside
          PH_HEADER, PH_WAVE:                             err_st = ST_NOT_WAVE;
          PH_ID1, PH_SIZE1, PH_SKIP1, PH_FMTSIZE, PH_FMTBODY: err_st = ST_NO_FMT;
          default:                                        err_st = ST_NO_DATA;
        endcase
        emit              = 1'b1;
        res_o.data        = '0;
        res_o.data.status = err_st;
        phase_d           = PH_DONE;
      end
    end
    res_o.valid = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      asm_q   <= '0;
      skip_q  <= '0;
      pos_q   <= '0;
      fsz_q   <= '0;
      ch_q    <= '0;
      rate_q  <= '0;
      dep_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      asm_q   <= asm_d;
      skip_q  <= skip_d;
      pos_q   <= pos_d;
      fsz_q   <= fsz_d;
      ch_q    <= ch_d;
      rate_q  <= rate_d;
      dep_q   <= dep_d;
    end
  end

endmodule

`default_nettype wire

### rtl/wav_header_parser.sv
// ----------------------------------------------------------------------------
// wav_header_parser
// byte-stream RIFF/WAVE header parser with registered result output
// ----------------------------------------------------------------------------
// Feed the file one byte per beat from its start, marking the first byte with
// first_byte (which restarts the parse at any time) and the final byte with
// last_byte. The block takes one byte each cycle that ready is high; the
// result for a byte appears on the output in the cycle after that byte is
// taken. Each byte costs a single pass through the parse state update, so
// throughput is one byte per cycle, and input ready drops only while the
// result register holds a beat that the output side has not yet taken. At most
// one result comes per file: the fmt fields with data length and offset, or an
// error status with all other fields zero. Bytes after the result, up to the
// next first_byte, are taken and dropped.
`default_nettype none

module wav_header_parser
  import wavhp_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  wavhp_stream_if.sink           in_i,
  wavhp_stream_if.source         out_o
);

  wavhp_res_t res;
  wavhp_out_t out_data_q, out_data_d;
  logic       out_vld_q, out_vld_d;
  logic       in_fire;

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  wavhp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .beat_i (in_i.payload),
    .res_o  (res)
  );

  always_comb begin
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (in_fire && res.valid) begin
      out_vld_d  = 1'b1;
      out_data_d = res.data;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_data_q;

`ifndef SYNTH
  a_rise_needs_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_fire))
    else $error("result appeared without an input beat");

  a_error_zeroes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q.status != ST_OK) |->
      (out_data_q.channels == '0 && out_data_q.sample_rate == '0 &&
       out_data_q.bits_per_sample == '0 && out_data_q.data_length == '0 &&
       out_data_q.data_offset == '0))
    else $error("error result carries nonzero fields");

  a_ok_depth_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q.status == ST_OK) |->
      (out_data_q.bits_per_sample[DEPTH_ALIGN_BITS-1:0] == '0))
    else $error("ok result with unaligned bit depth");
`endif

endmodule

`default_nettype wire

### dv/wav_header_parser_tb.sv
// ----------------------------------------------------------------------------
// wav_header_parser_tb
// self-checking testbench for the byte-stream wav header parser
// ----------------------------------------------------------------------------
// Builds RIFF/WAVE files byte by byte (junk chunks, short and extended fmt
// chunks, bad tags, bad bit depths, truncated and restarted files, stray
// bytes) and streams them into the parser with random gaps on both sides.
// A scoreboard class tracks the parse of every accepted beat, queues the
// expected result and checks each result beat field by field in order.
`timescale 1ns / 1ps

module wav_header_parser_tb;
  import wavhp_pkg::*;

  localparam int IDLE_LIMIT     = 3000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_BYTES   = 1100;
  localparam int HOLD_CYCLES    = 400;

  class wav_parse_scoreboard;
    phase_e      phase;
    logic [1:0]  field_idx;
    logic [31:0] word_acc;
    logic [31:0] skip_left;
    logic [31:0] byte_pos;
    logic [31:0] fmt_size;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] depth;
    wavhp_out_t  expected_results[$];
    int          errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      phase     = PH_IDLE;
      field_idx = '0;
      word_acc  = '0;
      skip_left = '0;
      byte_pos  = '0;
      fmt_size  = '0;
      chans     = '0;
      rate      = '0;
      depth     = '0;
    endfunction

    // little-endian word assembly, true once four bytes are in
    function bit shift_in(logic [7:0] b);
      word_acc = {b, word_acc[31:8]};
      if (field_idx == 2'd3) begin
        field_idx = 2'd0;
        return 1'b1;
      end
      field_idx = field_idx + 2'd1;
      return 1'b0;
    endfunction

    function void post_result(status_e st, logic [31:0] len, logic [31:0] off);
      wavhp_out_t r;
      r = '0;
      r.status = st;
      if (st == ST_OK) begin
        r.channels        = chans;
        r.sample_rate     = rate;
        r.bits_per_sample = depth;
        r.data_length     = len;
        r.data_offset     = off;
      end
      expected_results.push_back(r);
      phase = PH_DONE;
    endfunction

    function void note_byte(wavhp_in_t beat);
      logic [7:0] b;
      logic [3:0] ofs;
      bit         posted;
      b = beat.data_byte;
      posted = 1'b0;
      if (beat.first_byte) begin
        restart();
        phase = PH_HEADER;
      end else if (phase == PH_IDLE || phase == PH_DONE) begin
        return;
      end else begin
        byte_pos = byte_pos + 32'd1;
      end

      case (phase) inside
        PH_HEADER: begin
          if (byte_pos == 32'd7) phase = PH_WAVE;
        end
        PH_WAVE: begin
          if (shift_in(b)) begin
            if (word_acc != TAG_WAVE) begin
              post_result(ST_NOT_WAVE, '0, '0);
              posted = 1'b1;
            end else begin
              phase = PH_ID1;
            end
          end
        end
        PH_ID1: begin
          if (shift_in(b)) begin
            if (word_acc == TAG_FMT) phase = PH_FMTSIZE;
            else phase = PH_SIZE1;
          end
        end
        PH_ID2: begin
          if (shift_in(b)) begin
            if (word_acc == TAG_DATA) phase = PH_DLEN;
            else phase = PH_SIZE2;
          end
        end
        PH_SIZE1, PH_SIZE2: begin
          if (shift_in(b)) begin
            skip_left = word_acc;
            if (phase == PH_SIZE1) begin
              if (skip_left != 0) phase = PH_SKIP1;
              else phase = PH_ID1;
            end else begin
              if (skip_left != 0) phase = PH_SKIP2;
              else phase = PH_ID2;
            end
          end
        end
        PH_SKIP1, PH_SKIP2, PH_EXT: begin
          skip_left = skip_left - 32'd1;
          if (skip_left == 0) begin
            if (phase == PH_SKIP1) phase = PH_ID1;
            else phase = PH_ID2;
          end
        end
        PH_FMTSIZE: begin
          if (shift_in(b)) begin
            fmt_size  = word_acc;
            skip_left = '0;
            phase     = PH_FMTBODY;
          end
        end
        PH_FMTBODY: begin
          ofs = skip_left[3:0];
          case (ofs) inside
            4'd2:                   chans = {8'h00, b};
            4'd3:                   chans = chans | {b, 8'h00};
            4'd4, 4'd5, 4'd6, 4'd7: rate = rate | ({24'h0, b} << ((ofs - 4'd4) * 8));
            4'd14:                  depth = {8'h00, b};
            4'd15:                  depth = depth | {b, 8'h00};
            default: ;
          endcase
          skip_left = {28'h0, ofs} + 32'd1;
          if (ofs == 4'd15) begin
            if (depth[DEPTH_ALIGN_BITS-1:0] != 0) begin
              post_result(ST_BAD_DEPTH, '0, '0);
              posted = 1'b1;
            end else if (fmt_size > FMT_BASE_SIZE) begin
              skip_left = fmt_size - FMT_BASE_SIZE;
              phase     = PH_EXT;
            end else begin
              skip_left = '0;
              phase     = PH_ID2;
            end
          end
        end
        PH_DLEN: begin
          if (shift_in(b)) begin
            post_result(ST_OK, word_acc, byte_pos + 32'd1);
            posted = 1'b1;
          end
        end
        default: ;
      endcase

      // end of file before the parse finished
      if (!posted && beat.last_byte && phase != PH_DONE) begin
        if (phase inside {PH_HEADER, PH_WAVE})
          post_result(ST_NOT_WAVE, '0, '0);
        else if (phase inside {PH_ID1, PH_SIZE1, PH_SKIP1, PH_FMTSIZE, PH_FMTBODY})
          post_result(ST_NO_FMT, '0, '0);
        else
          post_result(ST_NO_DATA, '0, '0);
      end
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(wavhp_out_t got);
      wavhp_out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with none expected, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report("status", 32'(want.status), 32'(got.status));
      if (got.channels !== want.channels)
        report("channels", 32'(want.channels), 32'(got.channels));
      if (got.sample_rate !== want.sample_rate)
        report("sample_rate", want.sample_rate, got.sample_rate);
      if (got.bits_per_sample !== want.bits_per_sample)
        report("bits_per_sample", 32'(want.bits_per_sample), 32'(got.bits_per_sample));
      if (got.data_length !== want.data_length)
        report("data_length", want.data_length, got.data_length);
      if (got.data_offset !== want.data_offset)
        report("data_offset", want.data_offset, got.data_offset);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  typedef struct {
    logic [31:0] wave_tag;
    int          junk_before;
    int          junk_after;
    int          junk_size;
    logic [31:0] fmt_size;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] depth;
    logic [31:0] data_len;
    int          tail;
    bit          huge_junk;
    bit          huge_ext;
  } wav_recipe_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wavhp_stream_if #(.payload_t(wavhp_in_t))  byte_if ();
  wavhp_stream_if #(.payload_t(wavhp_out_t)) result_if ();

  wav_header_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (result_if)
  );

  wav_parse_scoreboard header_sb;
  logic [7:0]          file_bytes[$];
  int                  bytes_sent;
  int                  quiet_cycles;
  bit                  tx_calm;

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_le32(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic push_le16(logic [15:0] w);
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
  endtask

  task automatic push_junk(int size);
    int n;
    n = (size < 0) ? $urandom_range(0, 7) : size;
    push_le32($urandom);
    push_le32(n);
    repeat (n) file_bytes.push_back(rand_byte());
  endtask

  task automatic build_file(wav_recipe_t rc);
    file_bytes.delete();
    repeat (8) file_bytes.push_back(rand_byte());
    push_le32(rc.wave_tag);
    if (rc.huge_junk) begin
      push_le32($urandom);
      push_le32($urandom | 32'h8000_0000);
      repeat (6) file_bytes.push_back(rand_byte());
      return;
    end
    repeat (rc.junk_before) push_junk(rc.junk_size);
    push_le32(TAG_FMT);
    push_le32(rc.fmt_size);
    push_le16(16'($urandom_range(0, 65535)));
    push_le16(rc.chans);
    push_le32(rc.rate);
    push_le32($urandom);
    push_le16(16'($urandom_range(0, 65535)));
    push_le16(rc.depth);
    if (rc.huge_ext) begin
      repeat (5) file_bytes.push_back(rand_byte());
      return;
    end
    if (rc.fmt_size > FMT_BASE_SIZE)
      repeat (rc.fmt_size - FMT_BASE_SIZE) file_bytes.push_back(rand_byte());
    repeat (rc.junk_after) push_junk(rc.junk_size);
    push_le32(TAG_DATA);
    push_le32(rc.data_len);
    repeat (rc.tail) file_bytes.push_back(rand_byte());
  endtask

  function automatic wav_recipe_t base_recipe();
    wav_recipe_t rc;
    rc.wave_tag    = TAG_WAVE;
    rc.junk_before = 0;
    rc.junk_after  = 0;
    rc.junk_size   = -1;
    rc.fmt_size    = FMT_BASE_SIZE;
    rc.chans       = 16'd2;
    rc.rate        = 32'd44100;
    rc.depth       = 16'd16;
    rc.data_len    = 32'd1000;
    rc.tail        = 0;
    rc.huge_junk   = 1'b0;
    rc.huge_ext    = 1'b0;
    return rc;
  endfunction

  function automatic wav_recipe_t random_recipe();
    wav_recipe_t rc;
    int          r;
    rc = base_recipe();
    if ($urandom_range(0, 19) == 0) rc.wave_tag = $urandom;
    rc.junk_before = $urandom_range(0, 2);
    rc.junk_after  = $urandom_range(0, 2);
    r = $urandom_range(0, 99);
    if (r < 65)      rc.fmt_size = FMT_BASE_SIZE;
    else if (r < 80) rc.fmt_size = $urandom_range(0, 15);
    else if (r < 95) rc.fmt_size = $urandom_range(17, 24);
    else             rc.fmt_size = $urandom | 32'h100;
    rc.huge_ext  = (r >= 95);
    rc.huge_junk = ($urandom_range(0, 32) == 0);
    rc.chans     = 16'($urandom_range(0, 65535));
    rc.rate      = $urandom;
    rc.depth     = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) != 0) rc.depth[2:0] = 3'b000;
    rc.data_len  = $urandom;
    rc.tail      = $urandom_range(0, 3);
    return rc;
  endfunction

  task automatic send_byte(logic [7:0] b, bit first, bit last);
    wavhp_in_t beat;
    int        gap;
    beat.data_byte  = b;
    beat.first_byte = first;
    beat.last_byte  = last;
    gap = pick_gap(tx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.payload <= beat;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  task automatic send_file(int count, bit mark_last);
    if (count > file_bytes.size()) count = file_bytes.size();
    for (int i = 0; i < count; i++) begin
      send_byte(file_bytes[i], i == 0, mark_last && i == count - 1);
      bytes_sent++;
    end
  endtask

  task automatic send_noise(int n);
    repeat (n) send_byte(rand_byte(), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_recipe(wav_recipe_t rc);
    build_file(rc);
    send_file(file_bytes.size(), 1'b1);
  endtask

  task automatic run_directed();
    wav_recipe_t rc;
    int          cuts[9] = '{1, 4, 10, 14, 21, 40, 49, 53, 57};

    // stray beats before any file
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);

    rc = base_recipe();
    send_recipe(rc);

    rc.chans = '1; rc.rate = '1; rc.depth = 16'hFFF8; rc.data_len = '1;
    send_recipe(rc);
    rc.chans = '0; rc.rate = '0; rc.depth = '0; rc.data_len = '0;
    send_recipe(rc);

    rc = base_recipe();
    rc.wave_tag = TAG_FMT;
    send_recipe(rc);

    rc = base_recipe();
    rc.depth = 16'd12;
    send_recipe(rc);
    rc.depth = 16'hFFFF;
    send_recipe(rc);

    // short fmt chunks still carry a full body
    rc = base_recipe();
    rc.fmt_size = 32'd0;
    send_recipe(rc);
    rc.fmt_size = 32'd15;
    send_recipe(rc);

    // zero and odd chunk sizes, fmt extension
    rc = base_recipe();
    rc.junk_before = 2; rc.junk_after = 1; rc.junk_size = 0; rc.fmt_size = 32'd17;
    send_recipe(rc);
    rc.junk_size = 3; rc.fmt_size = 32'd21; rc.tail = 3;
    send_recipe(rc);
    send_noise(3);

    // end of file at cut points spread across the header
    rc = base_recipe();
    rc.junk_before = 1; rc.junk_size = 3; rc.fmt_size = 32'd20;
    build_file(rc);
    foreach (cuts[i]) send_file(cuts[i], 1'b1);

    rc = base_recipe();
    rc.huge_junk = 1'b1;
    send_recipe(rc);
    rc = base_recipe();
    rc.fmt_size = 32'hFFFF_FFFF; rc.huge_ext = 1'b1;
    send_recipe(rc);

    // restart in the middle of a file
    rc = base_recipe();
    build_file(rc);
    send_file(30, 1'b0);
    send_recipe(rc);
  endtask

  task automatic run_random();
    wav_recipe_t rc;
    int          start_bytes;
    int          n;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rc = random_recipe();
      build_file(rc);
      n = file_bytes.size();
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      send_file(n, $urandom_range(0, 6) != 0);
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 4));
    end
  endtask

  // result sink with random stalls and two long hold-offs
  initial begin
    int  stall;
    int  cyc;
    bit  calm;
    result_if.ready = 1'b0;
    stall = 0;
    cyc   = 0;
    calm  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 400 == 0) calm = ($urandom_range(0, 3) == 0);
      if (cyc == 1200 || cyc == 3000) stall = HOLD_CYCLES;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        stall--;
      end else begin
        result_if.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall = pick_gap(calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) header_sb.check_result(result_if.payload);
      if (byte_if.valid && byte_if.ready) header_sb.note_byte(byte_if.payload);
    end
    if ((result_if.valid && result_if.ready) || (byte_if.valid && byte_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    header_sb       = new();
    quiet_cycles    = 0;
    bytes_sent      = 0;
    tx_calm         = 1'b0;
    byte_if.valid   = 1'b0;
    byte_if.payload = '0;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random();

    @(negedge clk_i);
    byte_if.valid <= 1'b0;
    while (header_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (header_sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
